### rtl/rdc_pkg.sv
// rdc_pkg: shared types, constants and the digit lookup for the radix digit converter
// depends on nothing; imported by every rtl module of the block

package rdc_pkg;

   // radix register limits and reset value
   localparam int RADIX_W = 6;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   // result field widths
   localparam int CHAR_W = 7;
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_LAST = 5'd31;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_RADIX = 1'b0;

   // ascii codes of the digit set
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_A = 7'd65;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic next;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } status_type;

   // map a remainder to its ascii digit, 0-9 then A-Z
   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] rem);
      logic [CHAR_W-1:0] r;
      r = {1'b0, rem};
      if (rem < 6'd10)
         digit_ascii = ASCII_ZERO + r;
      else
         digit_ascii = ASCII_A + r - 7'd10;
   endfunction

endpackage

### rtl/rdc_regs.sv
// rdc_regs: apb-style register block holding the radix
// depends on rdc_pkg

module rdc_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rdc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rdc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rdc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [rdc_pkg::RADIX_W-1:0]     radix
);
   import rdc_pkg::*;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] wr_raw;
   logic               wr_en;

   // write strobe and clamp of the written value
   assign wr_raw = pwdata[RADIX_W-1:0];
   assign wr_en  = psel && penable && pwrite && (paddr[CSR_ADDR_W-1:2] == REG_RADIX);

   always_comb begin
      radix_in = radix_ff;
      if (wr_en) begin
         if (wr_raw < RADIX_MIN)
            radix_in = RADIX_MIN;
         else if (wr_raw > RADIX_MAX)
            radix_in = RADIX_MAX;
         else
            radix_in = wr_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         radix_ff <= RADIX_RESET;
      else
         radix_ff <= radix_in;
   end

   // read back
   always_comb begin
      unique case (paddr[CSR_ADDR_W-1:2])
         REG_RADIX: prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff};
         default:   prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign radix  = radix_ff;

endmodule

### rtl/rdc_datapath.sv
// rdc_datapath: bit-serial restoring divider, digit position and result fields
// depends on rdc_pkg; driven by commands from rdc_ctrl

module rdc_datapath #(
   parameter int CONV_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rdc_pkg::cmd_type             cmd,
   output rdc_pkg::status_type          status,
   input  logic [CONV_BITS-1:0]         value,
   input  logic [rdc_pkg::RADIX_W-1:0]  radix,
   output logic [rdc_pkg::CHAR_W-1:0]   digit_char,
   output logic [rdc_pkg::POS_W-1:0]    digit_position
);
   import rdc_pkg::*;

   logic [CONV_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [RADIX_W:0]     rem_sh;
   logic [RADIX_W:0]     rem_diff;
   logic                 fits;

   // one quotient bit per step: shift in the top dividend bit, trial subtract
   assign rem_sh   = {rem_ff, quo_ff[CONV_BITS-1]};
   assign fits     = rem_sh >= {1'b0, radix};
   assign rem_diff = rem_sh - {1'b0, radix};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (cmd.load) begin
         quo_in = value;
         rem_in = '0;
         pos_in = '0;
      end else if (cmd.step) begin
         quo_in = {quo_ff[CONV_BITS-2:0], fits};
         rem_in = fits ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
      end else if (cmd.next) begin
         rem_in = '0;
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         pos_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
      end
      quo_ff <= quo_in;
   end

   // result fields once a division has finished
   assign digit_char     = digit_ascii(rem_ff);
   assign digit_position = pos_ff;
   assign status.last    = (quo_ff == '0) || (pos_ff == POS_LAST);

   // remainder stays below the divisor while dividing
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> rem_ff < radix)
      else $error("remainder not below radix");

   // a new digit starts with a cleared remainder
   a_next_clears_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.next |=> rem_ff == '0)
      else $error("remainder not cleared for next digit");

   // position advances by one per digit
   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.next |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("digit position did not advance");

endmodule

### rtl/rdc_ctrl.sv
// rdc_ctrl: sequencer for request intake, divider steps and digit hand-off
// depends on rdc_pkg; commands rdc_datapath

module rdc_ctrl #(
   parameter int CONV_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rdc_pkg::cmd_type     cmd,
   input  rdc_pkg::status_type  status
);
   import rdc_pkg::*;

   localparam int CNT_W = $clog2(CONV_BITS);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CONV_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SHOW
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             req_ready_ff, req_ready_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_take, rsp_take;

   assign req_take = req_valid && req_ready_ff;
   assign rsp_take = rsp_valid_ff && rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.load     = 1'b1;
               cnt_in       = '0;
               req_ready_in = 1'b0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_END) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_SHOW;
            end
         end
         ST_SHOW: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (status.last) begin
                  req_ready_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.next = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // handshake flags follow the state
   a_ready_in_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff == (state_ff == ST_IDLE))
      else $error("request ready out of step with state");

   a_valid_in_show: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_SHOW))
      else $error("result valid out of step with state");

   // an accepted request starts a full division
   a_load_to_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DIVIDE && cnt_ff == '0)
      else $error("division did not start after request");

endmodule

### rtl/radix_digit_converter_core.sv
// radix_digit_converter_core: top level of the integer to base-n ascii converter
// depends on rdc_pkg, rdc_regs, rdc_ctrl, rdc_datapath
//
//   port group   direction   payload
//   req_*        in          value (32 bits)
//   rsp_*        out         digit_char (7), digit_position (5), last (1)
//   p*           apb         radix register at byte address 0
//
// each digit takes B steps of the one-bit-per-cycle restoring divider,
// B = min(VALUE_BITS, 32), and is then presented until taken.
// a request of n digits runs n such divisions before the block is idle again.
// one request is handled at a time; req_ready is high only when idle.
// a stalled result holds the sequencer in place until taken.
// synchronous reset sets the radix to 10 and returns the block to idle.

module radix_digit_converter_core #(
   parameter int VALUE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rdc_pkg::CHAR_W-1:0]      rsp_digit_char,
   output logic [rdc_pkg::POS_W-1:0]       rsp_digit_position,
   output logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rdc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rdc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rdc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import rdc_pkg::*;

   localparam int CONV_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;

   logic [RADIX_W-1:0] radix;
   cmd_type            cmd;
   status_type         status;

   // configuration registers
   rdc_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .radix   (radix)
   );

   // sequencer
   rdc_ctrl #(.CONV_BITS(CONV_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // divider and result fields
   rdc_datapath #(.CONV_BITS(CONV_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .value          (req_value[CONV_BITS-1:0]),
      .radix          (radix),
      .digit_char     (rsp_digit_char),
      .digit_position (rsp_digit_position)
   );

   assign rsp_last = status.last;

   // radix register never leaves its legal range
   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      radix >= RADIX_MIN && radix <= RADIX_MAX)
      else $error("radix out of range");

   // digits are always legal ascii codes
   a_digit_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) ||
                    (rsp_digit_char >= 7'd65 && rsp_digit_char <= 7'd90))
      else $error("digit outside the digit set");

   // intake and delivery never overlap
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a result is pending");

   // the final digit of a request returns the block to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("block not idle after final digit");

endmodule

### verif/radix_digit_converter_core_tb.sv
// radix_digit_converter_core_tb: self-checking bench for the base-n digit converter
// drives requests and radix register writes, predicts or looks up every digit and checks each result
// depends on rdc_pkg and radix_digit_converter_core

module radix_digit_converter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdc_pkg::*;

   localparam int RANDOM_ITEMS = 205;
   localparam int PHASE_ITEMS = 25;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 100;
   localparam int STUCK_LIMIT = 5000;
   localparam int REPORT_MAX = 10;
   localparam string DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam logic [CSR_ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_RADIX, 2'b00};
   localparam logic [31:0] EDGE_RADIX_WORDS [6] = '{32'd0, 32'd1, 32'd2, 32'd36, 32'd37, 32'd63};

   typedef enum {ROW_WRITE, ROW_VALUE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0] data;
      string digits;          // expected digits, most significant first; empty: predicted
   } plan_row_type;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic [POS_W-1:0] place;
      logic is_msd;
   } digit_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CHAR_W-1:0] rsp_digit_char;
   logic [POS_W-1:0] rsp_digit_position;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // shared between sender and receiver
   logic no_idle = 1'b0;
   int hold_token = 0;
   int tokens_seen = 0;
   int hold_left = 0;
   int failures = 0;
   logic [RADIX_W-1:0] base_now = RADIX_RESET;
   digit_rec_type digits_due[$];
   plan_row_type plan[$];

   radix_digit_converter_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_digit_position(rsp_digit_position),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register write as the block sees it: low six bits, clamped to 2..36
   function automatic void mirror_csr_write(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [31:0] data);
      logic [RADIX_W-1:0] r;
      if (addr[CSR_ADDR_W-1:2] == REG_RADIX) begin
         r = data[RADIX_W-1:0];
         if (r < RADIX_MIN)
            r = RADIX_MIN;
         else if (r > RADIX_MAX)
            r = RADIX_MAX;
         base_now = r;
      end
   endfunction

   // digits of value in the current base, least significant first, capped at 32
   function automatic void predict_digits(input logic [31:0] value);
      logic [31:0] rest;
      logic [31:0] rem;
      byte c;
      int pos;
      digit_rec_type d;
      rest = value;
      pos = 0;
      do begin
         rem = rest % 32'(base_now);
         rest = rest / 32'(base_now);
         c = DIGIT_SET.getc(int'(rem));
         d.code = c[CHAR_W-1:0];
         d.place = pos[POS_W-1:0];
         d.is_msd = (rest == 0) || (pos == 31);
         digits_due.push_back(d);
         pos++;
      end while (!d.is_msd);
   endfunction

   // expectation typed as a string, most significant digit first
   function automatic void expect_typed(input string s);
      byte c;
      digit_rec_type d;
      for (int p = 0; p < s.len(); p++) begin
         c = s.getc(s.len() - 1 - p);
         d.code = c[CHAR_W-1:0];
         d.place = p[POS_W-1:0];
         d.is_msd = (p == s.len() - 1);
         digits_due.push_back(d);
      end
   endfunction

   function automatic void add_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      plan_row_type row;
      row.kind = ROW_WRITE;
      row.addr = addr;
      row.data = data;
      row.digits = "";
      plan.push_back(row);
   endfunction

   function automatic void add_value(input logic [31:0] data, input string digits);
      plan_row_type row;
      row.kind = ROW_VALUE;
      row.addr = RADIX_ADDR;
      row.data = data;
      row.digits = digits;
      plan.push_back(row);
   endfunction

   // offer one request and hold it until taken; valid stays high afterwards
   task automatic offer_value(input logic [31:0] value, input string typed, input bit may_idle);
      if (may_idle && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      if (typed.len() != 0)
         expect_typed(typed);
      else
         predict_digits(value);
   endtask

   // drop valid and wait until every expected digit has come back
   task automatic wait_for_digits();
      req_valid <= 1'b0;
      do @(posedge clock); while (digits_due.size() != 0);
   endtask

   // apb write, then read the radix back through its own address
   task automatic write_radix_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      logic [CSR_DATA_W-1:0] seen;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mirror_csr_write(addr, data);
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= RADIX_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (seen !== CSR_DATA_W'(base_now)) begin
         failures++;
         if (failures <= REPORT_MAX)
            $display("radix readback mismatch: expected %0d, got %0d", base_now, seen);
      end
   endtask

   // random request value: full range, small, powers of two and truncated words
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5: v = $urandom_range(0, 40);
         6: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         7: begin
            v = 32'h1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1))
               v = v - 1;
         end
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   // random register word: mostly legal bases, some out of range or with high bits set
   function automatic logic [31:0] pick_radix_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(2, 36);
         6: return EDGE_RADIX_WORDS[$urandom_range(0, 5)];
         7: return $urandom_range(37, 63);
         default: return $urandom;
      endcase
   endfunction

   // result side: check each digit and pick the ready level for the next cycle
   always @(posedge clock) begin
      digit_rec_type got;
      digit_rec_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.code = rsp_digit_char;
            got.place = rsp_digit_position;
            got.is_msd = rsp_last;
            if (digits_due.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("unexpected digit: char %0d position %0d last %0d",
                           got.code, got.place, got.is_msd);
            end else begin
               want = digits_due.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= REPORT_MAX)
                     $display("digit mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              want.code, want.place, want.is_msd,
                              got.code, got.place, got.is_msd);
               end
            end
         end
         if (hold_token != tokens_seen) begin
            tokens_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 14);
         end
      end
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (psel && penable && pwrite && pready))
            stuck = 0;
         else
            stuck++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // stimulus
   initial begin
      bit steady;
      // directed plan, radix 10 after reset
      add_value(32'd0, "0");
      add_value(32'hFFFF_FFFF, "4294967295");
      add_value(32'd1234567890, "");
      add_value(32'd9, "9");
      add_value(32'd10, "10");
      add_write(RADIX_ADDR, 32'd16);
      add_value(32'hFFFF_FFFF, "FFFFFFFF");
      add_value(32'hDEAD_BEEF, "DEADBEEF");
      // base 2: the full word hits the 32 digit cap
      add_write(RADIX_ADDR, 32'd2);
      add_value(32'hFFFF_FFFF, "11111111111111111111111111111111");
      add_value(32'h8000_0000, "10000000000000000000000000000000");
      add_value(32'd0, "0");
      add_write(RADIX_ADDR, 32'd36);
      add_value(32'hFFFF_FFFF, "1Z141Z3");
      add_value(32'd35, "Z");
      add_value(32'd36, "10");
      // out of range writes clamp to the nearest legal base
      add_write(RADIX_ADDR, 32'd0);
      add_value(32'd5, "101");
      add_write(RADIX_ADDR, 32'd63);
      add_value(32'd71, "1Z");
      add_write(RADIX_ADDR, 32'd1);
      add_value(32'd6, "110");
      add_write(RADIX_ADDR, 32'd37);
      add_value(32'd0, "0");
      // only the low six bits are kept
      add_write(RADIX_ADDR, 32'h0000_004A);
      add_value(32'd255, "255");
      // a write to an unmapped address leaves the radix alone
      add_write(UNMAPPED_ADDR, 32'd3);
      add_value(32'd100, "100");
      add_write(RADIX_ADDR, 32'hFFFF_FFC7);
      add_value(32'h1234_5678, "");
      add_value(32'h5555_AAAA, "");

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            wait_for_digits();
            write_radix_csr(plan[i].addr, plan[i].data);
         end else begin
            offer_value(plan[i].data, plan[i].digits, 1'b1);
         end
      end

      // random part in phases, each with its own radix
      steady = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            wait_for_digits();
            if ($urandom_range(0, 7) == 0)
               write_radix_csr(UNMAPPED_ADDR, $urandom);
            write_radix_csr(RADIX_ADDR, pick_radix_word());
         end
         // receiver holds off while requests keep coming
         if (i == 60)
            hold_token <= hold_token + 1;
         // sender pauses until the block has drained
         if (i == 120)
            wait_for_digits();
         if (i == 140 || i == 180) begin
            steady = (i == 140);
            no_idle <= steady;
         end
         offer_value(pick_value(), "", !steady);
      end

      wait_for_digits();
      repeat (TAIL_CYCLES) @(posedge clock);
      failures += digits_due.size();
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
